### src/imf_pkg.sv
// Shared types and constants for the Ising Metropolis flip block.
package imf_pkg;

    localparam int SIDE_DEF    = 16;
    localparam int CMD_W       = 2;
    localparam int SITE_W      = 8;
    localparam int RND_W       = 32;
    localparam int ENERGY_W    = 11;
    localparam int ACC_W       = 48;
    localparam int CNT_W       = 32;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int RECIP_SHIFT = 16;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_TRIAL = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic {
        REG_TH4 = 1'b0,
        REG_TH8 = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_COL,
        ST_RD2,
        ST_EXEC,
        ST_SQR,
        ST_ACC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic rd_a_en;
        logic rd_b_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

### src/imf_lattice.sv
// Row-organized spin lattice memory with two read ports, one write port and refill after reset.
module imf_lattice #(
    parameter int SIDE = imf_pkg::SIDE_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  imf_pkg::mem_ctl_t         ctl,
    input  logic [$clog2(SIDE)-1:0]   rd_a_addr,
    input  logic [$clog2(SIDE)-1:0]   rd_b_addr,
    input  logic [$clog2(SIDE)-1:0]   wr_addr,
    input  logic [SIDE-1:0]           wr_data,
    output logic [SIDE-1:0]           rd_a_data,
    output logic [SIDE-1:0]           rd_b_data,
    output logic                      busy
);

    localparam int RW = $clog2(SIDE);

    logic [SIDE-1:0] mem [SIDE];
    logic [SIDE-1:0] rd_a_reg;
    logic [SIDE-1:0] rd_b_reg;
    logic [RW-1:0]   clr_cnt_reg;
    logic            busy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            busy_reg    <= 1'b1;
        end else if (busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + RW'(1);
            if (clr_cnt_reg == RW'(SIDE - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[clr_cnt_reg] <= '1;
        end else if (ctl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_a_en) begin
            rd_a_reg <= mem[rd_a_addr];
        end
        if (ctl.rd_b_en) begin
            rd_b_reg <= mem[rd_b_addr];
        end
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;
    assign busy      = busy_reg;

endmodule

### src/ising_metropolis_flip.sv
// Top level of the periodic Ising lattice with Metropolis trials and energy statistics.
//
//   channel  direction  handshake            payload
//   s_       in         s_valid / s_ready    command, site_index, spin_value, random_fraction
//   m_       out        m_valid / m_ready    accepted, spin_now, energy, totals, trials_done
//   apb      in         psel/penable/pready  accept_threshold_4 at 0x0, accept_threshold_8 at 0x4
//
// A request passes through row decode, three lattice row reads through the two read ports,
// update, squaring and accumulation before the next request is accepted.
// The result is loaded into the output register as the sequencer leaves its final step.
// After reset the lattice refills one row per cycle, with s_ready low until it is full.
// A result that is not taken holds the sequencer in its final step.
module ising_metropolis_flip #(
    parameter int SIDE = imf_pkg::SIDE_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [imf_pkg::CMD_W-1:0]              s_command,
    input  logic [imf_pkg::SITE_W-1:0]             s_site_index,
    input  logic                                   s_spin_value,
    input  logic [imf_pkg::RND_W-1:0]              s_random_fraction,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_accepted,
    output logic                                   m_spin_now,
    output logic signed [imf_pkg::ENERGY_W-1:0]    m_energy,
    output logic signed [imf_pkg::ACC_W-1:0]       m_energy_total,
    output logic [imf_pkg::ACC_W-1:0]              m_energy_square_total,
    output logic [imf_pkg::CNT_W-1:0]              m_trials_done,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [imf_pkg::APB_AW-1:0]             paddr,
    input  logic [imf_pkg::APB_DW-1:0]             pwdata,
    output logic [imf_pkg::APB_DW-1:0]             prdata,
    output logic                                   pready
);

    localparam int RW    = $clog2(SIDE);
    localparam int SITES = SIDE * SIDE;
    localparam int EW    = $clog2(2 * SITES + 1) + 1;
    localparam int SQ_W  = 2 * EW;
    localparam int SUM_W = imf_pkg::ACC_W + 1;
    localparam int RECIP = ((1 << imf_pkg::RECIP_SHIFT) + SIDE - 1) / SIDE;
    localparam int PROD_W = imf_pkg::SITE_W + imf_pkg::RECIP_SHIFT;

    imf_pkg::state_t   state_reg, state_next;
    imf_pkg::mem_ctl_t mem_ctl;
    imf_pkg::cmd_t     cmd_reg;

    logic [imf_pkg::SITE_W-1:0]     site_reg;
    logic                           spin_in_reg;
    logic [imf_pkg::RND_W-1:0]      rnd_reg;
    logic                           valid_reg;
    logic [RW-1:0]                  row_reg;
    logic [RW-1:0]                  col_reg;
    logic [SIDE-1:0]                rowc_reg;
    logic [SIDE-1:0]                rowu_reg;
    logic                           accepted_reg;
    logic                           spin_now_reg;
    logic signed [EW-1:0]           energy_reg, energy_next;
    logic [SQ_W-1:0]                sq_reg;
    logic signed [imf_pkg::ACC_W-1:0] etot_reg;
    logic [imf_pkg::ACC_W-1:0]      sqtot_reg;
    logic [imf_pkg::CNT_W-1:0]      trials_reg;
    logic [imf_pkg::RND_W-1:0]      th4_reg;
    logic [imf_pkg::RND_W-1:0]      th8_reg;

    logic                           m_valid_reg;
    logic                           m_accepted_reg;
    logic                           m_spin_now_reg;
    logic signed [imf_pkg::ENERGY_W-1:0] m_energy_reg;
    logic signed [imf_pkg::ACC_W-1:0]    m_etot_reg;
    logic [imf_pkg::ACC_W-1:0]      m_sqtot_reg;
    logic [imf_pkg::CNT_W-1:0]      m_trials_reg;

    logic [RW-1:0]                  rd_a_addr, rd_b_addr;
    logic [SIDE-1:0]                rd_a_data, rd_b_data;
    logic [SIDE-1:0]                new_row;
    logic                           busy;

    logic [PROD_W-1:0]              quot_prod;
    logic [imf_pkg::SITE_W-1:0]     row_full;
    logic [imf_pkg::SITE_W-1:0]     col_full;
    logic [RW-1:0]                  row_up, row_dn, col_l, col_r;
    logic                           s_bit, b_up, b_dn, b_l, b_r;
    logic [2:0]                     agree;
    logic signed [4:0]              delta;
    logic                           take, change, new_spin, is_trial, out_load;
    logic signed [SUM_W-1:0]        sum_e;
    logic [SUM_W-1:0]               sum_q;
    logic                           cfg_wr;

    // row and column decode
    assign quot_prod = PROD_W'(site_reg) * PROD_W'(RECIP);
    assign row_full  = quot_prod[PROD_W-1 -: imf_pkg::SITE_W];
    assign col_full  = site_reg - imf_pkg::SITE_W'(int'(row_reg) * SIDE);

    assign row_up = (row_reg == '0) ? RW'(SIDE - 1) : row_reg - RW'(1);
    assign row_dn = (row_reg == RW'(SIDE - 1)) ? '0 : row_reg + RW'(1);
    assign col_l  = (col_reg == '0) ? RW'(SIDE - 1) : col_reg - RW'(1);
    assign col_r  = (col_reg == RW'(SIDE - 1)) ? '0 : col_reg + RW'(1);

    // flip delta and decision
    assign s_bit = rowc_reg[col_reg];
    assign b_l   = rowc_reg[col_l];
    assign b_r   = rowc_reg[col_r];
    assign b_up  = rowu_reg[col_reg];
    assign b_dn  = rd_b_data[col_reg];
    assign agree = {2'b00, b_l == s_bit} + {2'b00, b_r == s_bit}
                 + {2'b00, b_up == s_bit} + {2'b00, b_dn == s_bit};
    assign delta = $signed({agree, 2'b00}) - 5'sd8;

    assign is_trial = valid_reg && (cmd_reg == imf_pkg::CMD_TRIAL);
    assign take = (agree <= 3'd2)
               || ((agree == 3'd3) && (rnd_reg < th4_reg))
               || ((agree == 3'd4) && (rnd_reg < th8_reg));
    assign change = valid_reg
                 && (((cmd_reg == imf_pkg::CMD_LOAD) && (spin_in_reg != s_bit))
                  || ((cmd_reg == imf_pkg::CMD_TRIAL) && take));
    assign new_spin    = change ? ~s_bit : s_bit;
    assign energy_next = change ? energy_reg + EW'(delta) : energy_reg;

    always_comb begin
        new_row          = rowc_reg;
        new_row[col_reg] = new_spin;
    end

    // statistics
    assign sum_e = SUM_W'(etot_reg) + SUM_W'(energy_reg);
    assign sum_q = SUM_W'(sqtot_reg) + SUM_W'(sq_reg);

    assign out_load = (state_reg == imf_pkg::ST_DONE) && (!m_valid_reg || m_ready);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            imf_pkg::ST_IDLE: begin
                if (s_valid && !busy) begin
                    state_next = imf_pkg::ST_DIV;
                end
            end
            imf_pkg::ST_DIV:  state_next = imf_pkg::ST_COL;
            imf_pkg::ST_COL:  state_next = imf_pkg::ST_RD2;
            imf_pkg::ST_RD2:  state_next = imf_pkg::ST_EXEC;
            imf_pkg::ST_EXEC: state_next = imf_pkg::ST_SQR;
            imf_pkg::ST_SQR:  state_next = imf_pkg::ST_ACC;
            imf_pkg::ST_ACC:  state_next = imf_pkg::ST_DONE;
            imf_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = imf_pkg::ST_IDLE;
                end
            end
            default: state_next = imf_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready   = 1'b0;
        mem_ctl   = '0;
        rd_a_addr = row_reg;
        rd_b_addr = row_up;
        case (state_reg)
            imf_pkg::ST_IDLE: s_ready = !busy;
            imf_pkg::ST_COL: begin
                mem_ctl.rd_a_en = 1'b1;
                mem_ctl.rd_b_en = 1'b1;
            end
            imf_pkg::ST_RD2: begin
                mem_ctl.rd_b_en = 1'b1;
                rd_b_addr       = row_dn;
            end
            imf_pkg::ST_EXEC: mem_ctl.wr_en = change;
            default: ;
        endcase
    end

    imf_lattice #(
        .SIDE(SIDE)
    ) u_lattice (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (mem_ctl),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .wr_addr   (row_reg),
        .wr_data   (new_row),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data),
        .busy      (busy)
    );

    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= imf_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            energy_reg  <= EW'(-2 * SITES);
            etot_reg    <= '0;
            sqtot_reg   <= '0;
            trials_reg  <= '0;
            th4_reg     <= '0;
            th8_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr) begin
                case (imf_pkg::reg_idx_t'(paddr[2]))
                    imf_pkg::REG_TH4: th4_reg <= pwdata;
                    imf_pkg::REG_TH8: th8_reg <= pwdata;
                    default: ;
                endcase
            end
            case (state_reg)
                imf_pkg::ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        cmd_reg     <= imf_pkg::cmd_t'(s_command);
                        site_reg    <= s_site_index;
                        spin_in_reg <= s_spin_value;
                        rnd_reg     <= s_random_fraction;
                        valid_reg   <= int'(s_site_index) < SITES;
                    end
                end
                imf_pkg::ST_DIV: row_reg <= row_full[RW-1:0];
                imf_pkg::ST_COL: col_reg <= col_full[RW-1:0];
                imf_pkg::ST_RD2: begin
                    rowc_reg <= rd_a_data;
                    rowu_reg <= rd_b_data;
                end
                imf_pkg::ST_EXEC: begin
                    energy_reg   <= energy_next;
                    accepted_reg <= is_trial && take;
                    spin_now_reg <= valid_reg && new_spin;
                end
                imf_pkg::ST_SQR: sq_reg <= SQ_W'(energy_reg) * SQ_W'(energy_reg);
                imf_pkg::ST_ACC: begin
                    if (is_trial) begin
                        if (sum_e[SUM_W-1] != sum_e[SUM_W-2]) begin
                            etot_reg <= {sum_e[SUM_W-1], {(imf_pkg::ACC_W-1){~sum_e[SUM_W-1]}}};
                        end else begin
                            etot_reg <= sum_e[imf_pkg::ACC_W-1:0];
                        end
                        sqtot_reg <= sum_q[SUM_W-1] ? '1 : sum_q[imf_pkg::ACC_W-1:0];
                        if (trials_reg != '1) begin
                            trials_reg <= trials_reg + imf_pkg::CNT_W'(1);
                        end
                    end else if (cmd_reg == imf_pkg::CMD_CLEAR) begin
                        etot_reg   <= '0;
                        sqtot_reg  <= '0;
                        trials_reg <= '0;
                    end
                end
                default: ;
            endcase
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_accepted_reg <= accepted_reg;
            m_spin_now_reg <= spin_now_reg;
            m_energy_reg   <= imf_pkg::ENERGY_W'(energy_reg);
            m_etot_reg     <= etot_reg;
            m_sqtot_reg    <= sqtot_reg;
            m_trials_reg   <= trials_reg;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_accepted            = m_accepted_reg;
    assign m_spin_now            = m_spin_now_reg;
    assign m_energy              = m_energy_reg;
    assign m_energy_total        = m_etot_reg;
    assign m_energy_square_total = m_sqtot_reg;
    assign m_trials_done         = m_trials_reg;

    assign pready = 1'b1;
    assign prdata = (imf_pkg::reg_idx_t'(paddr[2]) == imf_pkg::REG_TH8) ? th8_reg : th4_reg;

endmodule

### tb/sv/tb_ising_metropolis_flip.sv
// Testbench for ising_metropolis_flip: directed and random requests checked against a lattice predictor.
module tb_ising_metropolis_flip;

    localparam int              SIDE   = imf_pkg::SIDE_DEF;
    localparam int              SITES  = SIDE * SIDE;
    localparam int              LIMIT  = 200000;
    localparam longint          ACC_HI = 64'sd140737488355327;
    localparam longint          ACC_LO = -64'sd140737488355328;
    localparam longint unsigned SQ_HI  = 64'hFFFF_FFFF_FFFF;

    typedef struct {
        logic                                accepted;
        logic                                spin_now;
        logic signed [imf_pkg::ENERGY_W-1:0] energy;
        logic signed [imf_pkg::ACC_W-1:0]    energy_total;
        logic [imf_pkg::ACC_W-1:0]           square_total;
        logic [imf_pkg::CNT_W-1:0]           trials_done;
    } flip_result_t;

    logic                                aclk              = 1'b0;
    logic                                aresetn           = 1'b0;
    logic                                s_valid           = 1'b0;
    logic                                s_ready;
    logic [imf_pkg::CMD_W-1:0]           s_command         = '0;
    logic [imf_pkg::SITE_W-1:0]          s_site_index      = '0;
    logic                                s_spin_value      = 1'b0;
    logic [imf_pkg::RND_W-1:0]           s_random_fraction = '0;
    logic                                m_valid;
    logic                                m_ready           = 1'b0;
    logic                                m_accepted;
    logic                                m_spin_now;
    logic signed [imf_pkg::ENERGY_W-1:0] m_energy;
    logic signed [imf_pkg::ACC_W-1:0]    m_energy_total;
    logic [imf_pkg::ACC_W-1:0]           m_energy_square_total;
    logic [imf_pkg::CNT_W-1:0]           m_trials_done;
    logic                                psel              = 1'b0;
    logic                                penable           = 1'b0;
    logic                                pwrite            = 1'b0;
    logic [imf_pkg::APB_AW-1:0]          paddr             = '0;
    logic [imf_pkg::APB_DW-1:0]          pwdata            = '0;
    logic [imf_pkg::APB_DW-1:0]          prdata;
    logic                                pready;

    bit                                  lattice [SITES];
    int                                  energy_now;
    longint                              energy_sum;
    longint unsigned                     square_sum;
    int unsigned                         trial_count;
    logic [imf_pkg::RND_W-1:0]           bound4;
    logic [imf_pkg::RND_W-1:0]           bound8;
    flip_result_t                        pending_results [$];
    int                                  errors;
    int                                  cycles;
    bit                                  no_idle;

    ising_metropolis_flip #(
        .SIDE(SIDE)
    ) u_top (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_command             (s_command),
        .s_site_index          (s_site_index),
        .s_spin_value          (s_spin_value),
        .s_random_fraction     (s_random_fraction),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_accepted            (m_accepted),
        .m_spin_now            (m_spin_now),
        .m_energy              (m_energy),
        .m_energy_total        (m_energy_total),
        .m_energy_square_total (m_energy_square_total),
        .m_trials_done         (m_trials_done),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic int spin_pm(int site);
        return lattice[site] ? 1 : -1;
    endfunction

    function automatic int flip_cost(int site);
        int row;
        int col;
        int nsum;
        row  = site / SIDE;
        col  = site % SIDE;
        nsum = spin_pm(row * SIDE + (col + 1) % SIDE)
             + spin_pm(row * SIDE + (col + SIDE - 1) % SIDE)
             + spin_pm(((row + 1) % SIDE) * SIDE + col)
             + spin_pm(((row + SIDE - 1) % SIDE) * SIDE + col);
        return 2 * spin_pm(site) * nsum;
    endfunction

    function automatic flip_result_t step_lattice(imf_pkg::cmd_t cmd,
                                                  logic [imf_pkg::SITE_W-1:0] site,
                                                  logic spin,
                                                  logic [imf_pkg::RND_W-1:0] rnd);
        flip_result_t    r;
        int              s;
        int              cost;
        bit              in_range;
        bit              take;
        longint          sum;
        longint unsigned sq;
        s          = int'(site);
        in_range   = s < SITES;
        r.accepted = 1'b0;
        if (cmd == imf_pkg::CMD_LOAD && in_range) begin
            if (lattice[s] != spin) begin
                energy_now += flip_cost(s);
                lattice[s] = spin;
            end
        end else if (cmd == imf_pkg::CMD_TRIAL && in_range) begin
            cost = flip_cost(s);
            if (cost <= 0) begin
                take = 1'b1;
            end else if (cost == 4) begin
                take = rnd < bound4;
            end else begin
                take = rnd < bound8;
            end
            if (take) begin
                energy_now += cost;
                lattice[s] = !lattice[s];
                r.accepted = 1'b1;
            end
            sum = energy_sum + longint'(energy_now);
            if (sum > ACC_HI) sum = ACC_HI;
            if (sum < ACC_LO) sum = ACC_LO;
            energy_sum = sum;
            sq = longint'(energy_now) * longint'(energy_now);
            if (square_sum > SQ_HI - sq) begin
                square_sum = SQ_HI;
            end else begin
                square_sum += sq;
            end
            if (trial_count != 32'hFFFF_FFFF) trial_count++;
        end else if (cmd == imf_pkg::CMD_CLEAR) begin
            energy_sum  = 0;
            square_sum  = 0;
            trial_count = 0;
        end
        r.spin_now     = in_range ? lattice[s] : 1'b0;
        r.energy       = imf_pkg::ENERGY_W'(energy_now);
        r.energy_total = imf_pkg::ACC_W'(energy_sum);
        r.square_total = imf_pkg::ACC_W'(square_sum);
        r.trials_done  = trial_count;
        return r;
    endfunction

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 15);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        if (errors <= 100) begin
            $display("[cycle %0d] mismatch on %s: got %0h, want %0h", cycles, what, got, want);
        end
    endtask

    task automatic send_request(imf_pkg::cmd_t cmd, logic [imf_pkg::SITE_W-1:0] site,
                                logic spin, logic [imf_pkg::RND_W-1:0] rnd);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_command         <= cmd;
        s_site_index      <= site;
        s_spin_value      <= spin;
        s_random_fraction <= rnd;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(step_lattice(cmd, site, spin, rnd));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic set_bounds(logic [imf_pkg::APB_DW-1:0] b4, logic [imf_pkg::APB_DW-1:0] b8);
        imf_pkg::reg_idx_t          idx;
        logic [imf_pkg::APB_DW-1:0] value;
        for (int i = 0; i < 2; i++) begin
            idx   = imf_pkg::reg_idx_t'(i);
            value = (idx == imf_pkg::REG_TH4) ? b4 : b8;
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= imf_pkg::APB_AW'({idx, 2'b00});
            pwdata  <= value;
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            if (idx == imf_pkg::REG_TH4) begin
                bound4 = value;
            end else begin
                bound8 = value;
            end
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            if (prdata !== value)
                report_mismatch("threshold readback", 64'(prdata), 64'(value));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_request(imf_pkg::CMD_NONE, 8'd0, 1'b0, 32'h0);
        send_request(imf_pkg::CMD_TRIAL, 8'd0, 1'b1, 32'h0);
        send_request(imf_pkg::CMD_TRIAL, 8'd255, 1'b0, 32'hFFFF_FFFF);
    endtask

    task automatic test_load_spin();
        send_request(imf_pkg::CMD_LOAD, 8'd0, 1'b0, 32'hFFFF_FFFF);
        send_request(imf_pkg::CMD_LOAD, 8'd0, 1'b0, 32'h0);
        send_request(imf_pkg::CMD_LOAD, 8'd255, 1'b0, 32'h0);
        send_request(imf_pkg::CMD_LOAD, 8'd17, 1'b1, 32'h0);
        send_request(imf_pkg::CMD_LOAD, 8'd1, 1'b0, 32'h0);
        send_request(imf_pkg::CMD_NONE, 8'd255, 1'b1, 32'hFFFF_FFFF);
    endtask

    task automatic test_trial_bounds();
        drain();
        set_bounds(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(imf_pkg::CMD_TRIAL, 8'd2, 1'b0, 32'hFFFF_FFFF);
        send_request(imf_pkg::CMD_TRIAL, 8'd2, 1'b0, 32'hFFFF_FFFE);
        send_request(imf_pkg::CMD_TRIAL, 8'd4, 1'b0, 32'hFFFF_FFFE);
        send_request(imf_pkg::CMD_TRIAL, 8'd0, 1'b0, 32'hFFFF_FFFF);
        drain();
        set_bounds(32'h0000_0001, 32'h0000_0000);
        send_request(imf_pkg::CMD_TRIAL, 8'd34, 1'b1, 32'h0);
        send_request(imf_pkg::CMD_TRIAL, 8'd36, 1'b0, 32'h0);
        send_request(imf_pkg::CMD_TRIAL, 8'd3, 1'b0, 32'h1);
        send_request(imf_pkg::CMD_TRIAL, 8'd3, 1'b0, 32'h0);
    endtask

    task automatic test_clear_and_none();
        send_request(imf_pkg::CMD_CLEAR, 8'd128, 1'b1, 32'h5555_5555);
        send_request(imf_pkg::CMD_NONE, 8'd77, 1'b0, 32'hAAAA_AAAA);
        send_request(imf_pkg::CMD_TRIAL, 8'd254, 1'b1, 32'h0);
        send_request(imf_pkg::CMD_CLEAR, 8'd0, 1'b0, 32'h0);
        send_request(imf_pkg::CMD_TRIAL, 8'd16, 1'b0, 32'h0);
    endtask

    task automatic test_random_sweeps();
        int                         pick;
        int                         load_pct;
        imf_pkg::cmd_t              cmd;
        logic [imf_pkg::SITE_W-1:0] site;
        logic [imf_pkg::RND_W-1:0]  rnd;
        for (int phase = 0; phase < 6; phase++) begin
            drain();
            case (phase)
                0: set_bounds(32'h0000_0000, 32'h0000_0000);
                1: set_bounds(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                2: set_bounds(32'h2C00_0000, 32'h0790_0000);
                3: set_bounds($urandom, $urandom);
                4: set_bounds(32'h8000_0000, 32'h4000_0000);
                default: set_bounds(32'h0000_0001, 32'hFFFF_FFFF);
            endcase
            no_idle  = (phase % 3 == 1);
            load_pct = (phase == 0) ? 60 : 22;
            for (int n = 0; n < 105; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < load_pct) begin
                    cmd = imf_pkg::CMD_LOAD;
                end else if (pick < load_pct + 4) begin
                    cmd = imf_pkg::CMD_CLEAR;
                end else if (pick < load_pct + 7) begin
                    cmd = imf_pkg::CMD_NONE;
                end else begin
                    cmd = imf_pkg::CMD_TRIAL;
                end
                if ($urandom_range(0, 7) == 0) begin
                    site = $urandom_range(0, 1) ? imf_pkg::SITE_W'(SITES - 1) : '0;
                end else begin
                    site = imf_pkg::SITE_W'($urandom);
                end
                case ($urandom_range(0, 11))
                    0: rnd = '0;
                    1: rnd = '1;
                    2: rnd = bound4;
                    3: rnd = bound8 - 1;
                    default: rnd = $urandom;
                endcase
                send_request(cmd, site, 1'($urandom), rnd);
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin : drive_ready
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        flip_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending", 64'(m_energy), '0);
            end else begin
                want = pending_results.pop_front();
                if (m_accepted !== want.accepted)
                    report_mismatch("accepted", 64'(m_accepted), 64'(want.accepted));
                if (m_spin_now !== want.spin_now)
                    report_mismatch("spin_now", 64'(m_spin_now), 64'(want.spin_now));
                if (m_energy !== want.energy)
                    report_mismatch("energy", 64'(m_energy), 64'(want.energy));
                if (m_energy_total !== want.energy_total)
                    report_mismatch("energy_total", 64'(m_energy_total),
                                    64'(want.energy_total));
                if (m_energy_square_total !== want.square_total)
                    report_mismatch("energy_square_total", 64'(m_energy_square_total),
                                    64'(want.square_total));
                if (m_trials_done !== want.trials_done)
                    report_mismatch("trials_done", 64'(m_trials_done),
                                    64'(want.trials_done));
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < SITES; i++) lattice[i] = 1'b1;
        energy_now  = -2 * SITES;
        energy_sum  = 0;
        square_sum  = 0;
        trial_count = 0;
        bound4      = '0;
        bound8      = '0;
        errors      = 0;
        cycles      = 0;
        no_idle     = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_load_spin();
        test_trial_bounds();
        test_clear_and_none();
        test_random_sweeps();
        drain();
        repeat (16) @(posedge aclk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
src/imf_pkg.sv
src/imf_lattice.sv
src/ising_metropolis_flip.sv
tb/sv/tb_ising_metropolis_flip.sv
